>>> rtl/rau_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rational arithmetic unit package
// Shared widths, operation codes, controller states and the command and
// status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package rau_pkg;

    localparam int NUM_IN_W   = 32;
    localparam int DEN_IN_W   = 31;
    localparam int WIDE_W     = 64;
    localparam int DEN_OUT_W  = 63;
    localparam int SHIFT_W    = 6;
    localparam int DIV_STEPS  = 64;
    localparam int DIV_CNT_W  = 6;
    localparam int MUL_OP_W   = 33;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_NUM,
        MUL_DEN,
        MUL_E1,
        MUL_E2,
        MUL_L
    } mul_op_t;

    typedef enum logic [1:0] {
        DIV_Q1,
        DIV_Q2,
        DIV_AN,
        DIV_AD
    } div_sel_t;

    typedef enum logic {
        GCD_DEN,
        GCD_MAG
    } gcd_src_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_GCD_DEN,
        ST_DIV_INIT,
        ST_DIV_RUN,
        ST_DIV_TAKE,
        ST_MUL_E1,
        ST_MUL_E2,
        ST_MUL_L,
        ST_SUM,
        ST_MUL_DEN,
        ST_MAG,
        ST_GCD_MAG_INIT,
        ST_GCD_MAG,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic     load_in;
        logic     gcd_init;
        gcd_src_t gcd_src;
        logic     gcd_step;
        logic     gcd_take;
        logic     div_init;
        logic     div_step;
        logic     div_take;
        div_sel_t div_sel;
        mul_op_t  mul_op;
        logic     sum;
        logic     mag;
        logic     out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic add_sub;
        logic gcd_done;
        logic gcd_zero;
    } dp_stat_t;

endpackage

>>> rtl/rau_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rational arithmetic unit datapath
// Operand registers, a shared signed multiplier, a binary GCD engine and a
// restoring divider producing one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rau_datapath (
    input  logic                                clk,
    input  rau_pkg::dp_cmd_t                    cmd,
    output rau_pkg::dp_stat_t                   stat,
    input  logic [1:0]                          command,
    input  logic signed [rau_pkg::NUM_IN_W-1:0] r1_numerator,
    input  logic [rau_pkg::DEN_IN_W-1:0]        r1_denominator,
    input  logic signed [rau_pkg::NUM_IN_W-1:0] r2_numerator,
    input  logic [rau_pkg::DEN_IN_W-1:0]        r2_denominator,
    output logic signed [rau_pkg::WIDE_W-1:0]   result_numerator,
    output logic [rau_pkg::DEN_OUT_W-1:0]       result_denominator,
    output logic                                status
);

    rau_pkg::op_t                        op_reg;
    logic signed [rau_pkg::NUM_IN_W-1:0] n1_reg, n2_reg;
    logic [rau_pkg::DEN_IN_W-1:0]        d1_reg, d2_reg, q1_reg, q2_reg;
    logic signed [rau_pkg::WIDE_W-1:0]   e1_reg, e2_reg, n_reg, d_reg;
    logic [rau_pkg::WIDE_W-1:0]          an_reg, ad_reg, g_reg;
    logic                                neg_reg, nneg_reg;
    logic [rau_pkg::WIDE_W-1:0]          u_reg, v_reg, u_next, v_next;
    logic [rau_pkg::SHIFT_W-1:0]         k_reg, k_next;
    logic [rau_pkg::WIDE_W-1:0]          rem_reg, quo_reg, dvs_reg, dividend;
    logic [rau_pkg::WIDE_W:0]            rem_shift, rem_diff;
    logic signed [rau_pkg::MUL_OP_W-1:0] ma, mb;
    logic signed [2*rau_pkg::MUL_OP_W-1:0] prod;
    logic                                u_zero, v_zero;
    logic [rau_pkg::WIDE_W-1:0]          gcd_val;
    logic signed [rau_pkg::WIDE_W-1:0]   num_out_reg;
    logic [rau_pkg::DEN_OUT_W-1:0]       den_out_reg;
    logic                                status_reg;

    assign stat.add_sub  = (op_reg == rau_pkg::OP_ADD) || (op_reg == rau_pkg::OP_SUB);
    assign u_zero        = (u_reg == '0);
    assign v_zero        = (v_reg == '0);
    assign stat.gcd_done = u_zero || v_zero;
    assign stat.gcd_zero = u_zero && v_zero;
    assign gcd_val       = (u_zero ? v_reg : u_reg) << k_reg;

    // One binary GCD step: strip a factor of two or subtract the smaller odd value.
    always_comb
    begin
        u_next = u_reg;
        v_next = v_reg;
        k_next = k_reg;
        if (!u_reg[0] && !v_reg[0])
        begin
            u_next = u_reg >> 1;
            v_next = v_reg >> 1;
            k_next = k_reg + 1'b1;
        end
        else if (!u_reg[0])
            u_next = u_reg >> 1;
        else if (!v_reg[0])
            v_next = v_reg >> 1;
        else if (u_reg >= v_reg)
            u_next = (u_reg - v_reg) >> 1;
        else
            v_next = (v_reg - u_reg) >> 1;
    end

    always_comb
    begin
        ma = '0;
        mb = '0;
        case (cmd.mul_op)
            rau_pkg::MUL_NUM:
            begin
                ma = rau_pkg::MUL_OP_W'(n1_reg);
                if (op_reg == rau_pkg::OP_DIV)
                    mb = $signed({2'b00, d2_reg});
                else
                    mb = rau_pkg::MUL_OP_W'(n2_reg);
            end
            rau_pkg::MUL_DEN:
            begin
                if (op_reg == rau_pkg::OP_DIV)
                    ma = rau_pkg::MUL_OP_W'(n2_reg);
                else
                    ma = $signed({2'b00, d2_reg});
                mb = $signed({2'b00, d1_reg});
            end
            rau_pkg::MUL_E1:
            begin
                ma = rau_pkg::MUL_OP_W'(n1_reg);
                mb = $signed({2'b00, q2_reg});
            end
            rau_pkg::MUL_E2:
            begin
                ma = rau_pkg::MUL_OP_W'(n2_reg);
                mb = $signed({2'b00, q1_reg});
            end
            rau_pkg::MUL_L:
            begin
                ma = $signed({2'b00, q1_reg});
                mb = $signed({2'b00, d2_reg});
            end
            default:
            begin
                ma = '0;
                mb = '0;
            end
        endcase
    end

    assign prod = ma * mb;

    always_comb
    begin
        case (cmd.div_sel)
            rau_pkg::DIV_Q1: dividend = rau_pkg::WIDE_W'(d1_reg);
            rau_pkg::DIV_Q2: dividend = rau_pkg::WIDE_W'(d2_reg);
            rau_pkg::DIV_AN: dividend = an_reg;
            default:         dividend = ad_reg;
        endcase
    end

    assign rem_shift = {rem_reg, quo_reg[rau_pkg::WIDE_W-1]};
    assign rem_diff  = rem_shift - {1'b0, dvs_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            op_reg <= rau_pkg::op_t'(command);
            n1_reg <= r1_numerator;
            n2_reg <= r2_numerator;
            // A zero denominator is taken as one.
            d1_reg <= (r1_denominator == '0) ? rau_pkg::DEN_IN_W'(1) : r1_denominator;
            d2_reg <= (r2_denominator == '0) ? rau_pkg::DEN_IN_W'(1) : r2_denominator;
        end

        if (cmd.gcd_init)
        begin
            k_reg <= '0;
            if (cmd.gcd_src == rau_pkg::GCD_DEN)
            begin
                u_reg <= rau_pkg::WIDE_W'(d1_reg);
                v_reg <= rau_pkg::WIDE_W'(d2_reg);
            end
            else
            begin
                u_reg <= an_reg;
                v_reg <= ad_reg;
            end
        end
        else if (cmd.gcd_step)
        begin
            u_reg <= u_next;
            v_reg <= v_next;
            k_reg <= k_next;
        end

        if (cmd.gcd_take)
            g_reg <= gcd_val;

        if (cmd.div_init)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= g_reg;
        end
        else if (cmd.div_step)
        begin
            if (!rem_diff[rau_pkg::WIDE_W])
            begin
                rem_reg <= rem_diff[rau_pkg::WIDE_W-1:0];
                quo_reg <= {quo_reg[rau_pkg::WIDE_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_shift[rau_pkg::WIDE_W-1:0];
                quo_reg <= {quo_reg[rau_pkg::WIDE_W-2:0], 1'b0};
            end
        end

        if (cmd.div_take)
        begin
            case (cmd.div_sel)
                rau_pkg::DIV_Q1: q1_reg <= quo_reg[rau_pkg::DEN_IN_W-1:0];
                rau_pkg::DIV_Q2: q2_reg <= quo_reg[rau_pkg::DEN_IN_W-1:0];
                rau_pkg::DIV_AN: an_reg <= quo_reg;
                default:         ad_reg <= quo_reg;
            endcase
        end

        case (cmd.mul_op)
            rau_pkg::MUL_NUM: n_reg  <= prod[rau_pkg::WIDE_W-1:0];
            rau_pkg::MUL_DEN: d_reg  <= prod[rau_pkg::WIDE_W-1:0];
            rau_pkg::MUL_E1:  e1_reg <= prod[rau_pkg::WIDE_W-1:0];
            rau_pkg::MUL_E2:  e2_reg <= prod[rau_pkg::WIDE_W-1:0];
            rau_pkg::MUL_L:   d_reg  <= prod[rau_pkg::WIDE_W-1:0];
            default:          ;
        endcase

        if (cmd.sum)
            n_reg <= (op_reg == rau_pkg::OP_SUB) ? e1_reg - e2_reg : e1_reg + e2_reg;

        if (cmd.mag)
        begin
            an_reg   <= n_reg[rau_pkg::WIDE_W-1] ? -n_reg : n_reg;
            ad_reg   <= d_reg[rau_pkg::WIDE_W-1] ? -d_reg : d_reg;
            neg_reg  <= n_reg[rau_pkg::WIDE_W-1] ^ d_reg[rau_pkg::WIDE_W-1];
            nneg_reg <= n_reg[rau_pkg::WIDE_W-1];
        end

        if (cmd.out_load)
        begin
            if (ad_reg == '0)
            begin
                // Division by zero: the dividend's sign over zero.
                num_out_reg <= nneg_reg ? -$signed(an_reg) : $signed(an_reg);
                den_out_reg <= '0;
                status_reg  <= 1'b1;
            end
            else
            begin
                num_out_reg <= (neg_reg && an_reg != '0) ? -$signed(an_reg) : $signed(an_reg);
                den_out_reg <= ad_reg[rau_pkg::DEN_OUT_W-1:0];
                status_reg  <= 1'b0;
            end
        end
    end

    assign result_numerator   = num_out_reg;
    assign result_denominator = den_out_reg;
    assign status             = status_reg;

endmodule

>>> rtl/rau_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rational arithmetic unit controller
// Sequences GCD, division and multiply steps in the datapath and owns both
// stream handshakes.
// ----------------------------------------------------------------------------
module rau_controller (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output rau_pkg::dp_cmd_t        cmd,
    input  rau_pkg::dp_stat_t       stat
);

    rau_pkg::state_t                state_reg, state_next;
    rau_pkg::div_sel_t              dsel_reg, dsel_next;
    logic [rau_pkg::DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic                           out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rau_pkg::ST_IDLE;
            dsel_reg      <= rau_pkg::DIV_Q1;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            dsel_reg      <= dsel_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        dsel_next      = dsel_reg;
        cnt_next       = cnt_reg;
        s_tready       = 1'b0;
        out_valid_next = out_valid_reg && !m_tready;
        case (state_reg)
            rau_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = rau_pkg::ST_DISPATCH;
                end
            end
            rau_pkg::ST_DISPATCH:
            begin
                if (stat.add_sub)
                begin
                    cmd.gcd_init = 1'b1;
                    cmd.gcd_src  = rau_pkg::GCD_DEN;
                    state_next   = rau_pkg::ST_GCD_DEN;
                end
                else
                begin
                    cmd.mul_op = rau_pkg::MUL_NUM;
                    state_next = rau_pkg::ST_MUL_DEN;
                end
            end
            rau_pkg::ST_GCD_DEN:
            begin
                if (stat.gcd_done)
                begin
                    cmd.gcd_take = 1'b1;
                    dsel_next    = rau_pkg::DIV_Q1;
                    state_next   = rau_pkg::ST_DIV_INIT;
                end
                else
                    cmd.gcd_step = 1'b1;
            end
            rau_pkg::ST_DIV_INIT:
            begin
                cmd.div_init = 1'b1;
                cmd.div_sel  = dsel_reg;
                cnt_next     = '0;
                state_next   = rau_pkg::ST_DIV_RUN;
            end
            rau_pkg::ST_DIV_RUN:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == rau_pkg::DIV_CNT_W'(rau_pkg::DIV_STEPS - 1))
                    state_next = rau_pkg::ST_DIV_TAKE;
            end
            rau_pkg::ST_DIV_TAKE:
            begin
                cmd.div_take = 1'b1;
                cmd.div_sel  = dsel_reg;
                case (dsel_reg)
                    rau_pkg::DIV_Q1:
                    begin
                        dsel_next  = rau_pkg::DIV_Q2;
                        state_next = rau_pkg::ST_DIV_INIT;
                    end
                    rau_pkg::DIV_Q2: state_next = rau_pkg::ST_MUL_E1;
                    rau_pkg::DIV_AN:
                    begin
                        dsel_next  = rau_pkg::DIV_AD;
                        state_next = rau_pkg::ST_DIV_INIT;
                    end
                    default: state_next = rau_pkg::ST_FINISH;
                endcase
            end
            rau_pkg::ST_MUL_E1:
            begin
                cmd.mul_op = rau_pkg::MUL_E1;
                state_next = rau_pkg::ST_MUL_E2;
            end
            rau_pkg::ST_MUL_E2:
            begin
                cmd.mul_op = rau_pkg::MUL_E2;
                state_next = rau_pkg::ST_MUL_L;
            end
            rau_pkg::ST_MUL_L:
            begin
                cmd.mul_op = rau_pkg::MUL_L;
                state_next = rau_pkg::ST_SUM;
            end
            rau_pkg::ST_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = rau_pkg::ST_MAG;
            end
            rau_pkg::ST_MUL_DEN:
            begin
                cmd.mul_op = rau_pkg::MUL_DEN;
                state_next = rau_pkg::ST_MAG;
            end
            rau_pkg::ST_MAG:
            begin
                cmd.mag    = 1'b1;
                state_next = rau_pkg::ST_GCD_MAG_INIT;
            end
            rau_pkg::ST_GCD_MAG_INIT:
            begin
                cmd.gcd_init = 1'b1;
                cmd.gcd_src  = rau_pkg::GCD_MAG;
                state_next   = rau_pkg::ST_GCD_MAG;
            end
            rau_pkg::ST_GCD_MAG:
            begin
                if (stat.gcd_done)
                begin
                    cmd.gcd_take = 1'b1;
                    // Both magnitudes zero: nothing to reduce.
                    if (stat.gcd_zero)
                        state_next = rau_pkg::ST_FINISH;
                    else
                    begin
                        dsel_next  = rau_pkg::DIV_AN;
                        state_next = rau_pkg::ST_DIV_INIT;
                    end
                end
                else
                    cmd.gcd_step = 1'b1;
            end
            rau_pkg::ST_FINISH:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = rau_pkg::ST_IDLE;
                end
            end
            default: state_next = rau_pkg::ST_IDLE;
        endcase
    end

    assign m_tvalid = out_valid_reg;

    a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == rau_pkg::ST_DISPATCH))
        else $error("accepted transfer did not start processing");

    a_div_length: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rau_pkg::ST_DIV_INIT) |=> (state_reg == rau_pkg::ST_DIV_RUN && cnt_reg == '0))
        else $error("divider did not start from a cleared count");

    a_div_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rau_pkg::ST_DIV_RUN &&
         cnt_reg == rau_pkg::DIV_CNT_W'(rau_pkg::DIV_STEPS - 1))
        |=> (state_reg == rau_pkg::ST_DIV_TAKE))
        else $error("divider ran past its step count");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || m_tready))
        else $error("result overwritten before transfer");

    a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == rau_pkg::ST_FINISH))
        else $error("result raised outside the finish step");

endmodule

>>> rtl/rational_arithmetic_unit_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rational arithmetic unit
// Adds, subtracts, multiplies or divides two fractions and reduces the result.
// ----------------------------------------------------------------------------
// Usage: one transfer on the s_ stream carries an operation and two fractions;
// one transfer on the m_ stream carries the reduced result and a status flag
// (set on division by a zero fraction, with the dividend's sign over zero).
// The block works on one item at a time; the next item can be accepted once
// the current one has passed its final step. Processing runs binary GCD steps,
// one subtract-and-shift or shift per cycle, for the denominators of add and
// subtract and for the final reduction, and restoring divisions, each with its
// own set-up and take steps: two divisions for multiply and divide, four for
// add and subtract. When both magnitudes are zero the final two divisions are
// skipped.
// The result sits in an output register; the next item is taken while it
// waits, and processing stalls only at the final step if the receiver has
// not yet taken the previous result.
// Reset clears the controller and drops m_tvalid; no memory needs clearing.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit_core (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // command[1:0], r1_numerator[33:2], r1_denominator[64:34],
    // r2_numerator[96:65], r2_denominator[127:97]
    input  logic [127:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // result_numerator[63:0], result_denominator[126:64], zero [127]
    output logic [127:0] m_tdata,
    // status[0]
    output logic         m_tuser
);

    rau_pkg::dp_cmd_t                        cmd;
    rau_pkg::dp_stat_t                       stat;
    logic signed [rau_pkg::WIDE_W-1:0]       result_numerator;
    logic [rau_pkg::DEN_OUT_W-1:0]           result_denominator;

    rau_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    rau_datapath u_dp (
        .clk                (clk),
        .cmd                (cmd),
        .stat               (stat),
        .command            (s_tdata[1:0]),
        .r1_numerator       ($signed(s_tdata[33:2])),
        .r1_denominator     (s_tdata[64:34]),
        .r2_numerator       ($signed(s_tdata[96:65])),
        .r2_denominator     (s_tdata[127:97]),
        .result_numerator   (result_numerator),
        .result_denominator (result_denominator),
        .status             (m_tuser)
    );

    assign m_tdata = {1'b0, result_denominator, result_numerator};

endmodule

>>> bench/rational_arithmetic_unit_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rational arithmetic unit testbench
// Drives fraction pairs and operations into the core and checks every reduced
// result against a predictor of the arithmetic. A short table of directed
// cases comes first. Random cases follow, under several patterns of source
// gaps and sink back-pressure.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit_core_tb;

    localparam int RAND_ITEMS = 1350;
    localparam int WATCHDOG   = 20000;
    localparam int HOLD_LEN   = 3000;

    typedef struct {
        logic [63:0] num;
        logic [62:0] den;
        logic        st;
    } frac_res_t;

    typedef struct {
        rau_pkg::op_t op;
        logic [31:0]  n1;
        logic [30:0]  d1;
        logic [31:0]  n2;
        logic [30:0]  d2;
        logic         typed;
        frac_res_t    res;
    } case_row_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [127:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [127:0] m_tdata;
    logic         m_tuser;

    frac_res_t    pending_q[$];
    int           errors = 0;
    int           quiet_cycles = 0;
    int           phase;
    bit           hold_done;

    rational_arithmetic_unit_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    function automatic logic [63:0] euclid_gcd(logic [63:0] a, logic [63:0] b);
        logic [63:0] t;
        while (b != 0)
        begin
            t = a % b;
            a = b;
            b = t;
        end
        return a;
    endfunction

    function automatic frac_res_t reduce_fraction(rau_pkg::op_t op, logic [31:0] n1_in,
                                                  logic [30:0] d1_in, logic [31:0] n2_in,
                                                  logic [30:0] d2_in);
        longint      n1, d1, n2, d2, g12, l, n, d;
        logic [63:0] an, ad, g;
        bit          neg;
        frac_res_t   r;
        n1 = longint'(signed'(n1_in));
        n2 = longint'(signed'(n2_in));
        // A zero denominator is taken as one.
        d1 = (d1_in == 0) ? 64'sd1 : longint'({33'b0, d1_in});
        d2 = (d2_in == 0) ? 64'sd1 : longint'({33'b0, d2_in});
        case (op)
            rau_pkg::OP_ADD, rau_pkg::OP_SUB:
            begin
                g12 = longint'(euclid_gcd(d1, d2));
                l = (d1 / g12) * d2;
                n = (op == rau_pkg::OP_ADD) ? n1 * (l / d1) + n2 * (l / d2)
                                            : n1 * (l / d1) - n2 * (l / d2);
                d = l;
            end
            rau_pkg::OP_MUL:
            begin
                n = n1 * n2;
                d = d1 * d2;
            end
            default:
            begin
                n = n1 * d2;
                d = n2 * d1;
            end
        endcase
        an = (n < 0) ? 64'd0 - n : n;
        ad = (d < 0) ? 64'd0 - d : d;
        neg = (n < 0) != (d < 0);
        g = euclid_gcd(an, ad);
        if (g != 0)
        begin
            an = an / g;
            ad = ad / g;
        end
        if (ad == 0)
        begin
            r.num = (n < 0) ? 64'd0 - an : an;
            r.den = '0;
            r.st  = 1'b1;
        end
        else
        begin
            r.num = (neg && an != 0) ? 64'd0 - an : an;
            r.den = ad[62:0];
            r.st  = 1'b0;
        end
        return r;
    endfunction

    function automatic int gap_len(int idle_pct);
        if ($urandom_range(99) >= idle_pct)
            return 0;
        return $urandom_range(6, 1);
    endfunction

    task automatic send_item(rau_pkg::op_t op, logic [31:0] n1, logic [30:0] d1,
                             logic [31:0] n2, logic [30:0] d2, frac_res_t want);
        int gap;
        gap = gap_len((phase == 1) ? 84 : ((phase == 3) ? 16 : 0));
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {d2, n2, d1, n1, op};
        do
            @(posedge clk);
        while (!s_tready);
        pending_q.push_back(want);
        @(negedge clk);
    endtask

    function automatic logic [31:0] pick_numerator();
        case ($urandom_range(5))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2, 3:    return 32'(signed'($urandom_range(40)) - 20);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [30:0] pick_denominator();
        case ($urandom_range(19))
            0:       return '0;
            1:       return 31'h7fff_ffff;
            2, 3, 4,
            5, 6, 7: return 31'($urandom_range(30, 1));
            default: return 31'($urandom);
        endcase
    endfunction

    // Sink: back-pressure by phase, with one long hold while the source runs on.
    initial
    begin
        int hold_cnt;
        m_tready  = 1'b0;
        hold_cnt  = 0;
        hold_done = 1'b0;
        forever
        begin
            @(negedge clk);
            if (phase == 2 && !hold_done)
            begin
                hold_done = 1'b1;
                hold_cnt  = HOLD_LEN;
            end
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                m_tready <= 1'b0;
            end
            else if (phase == 2)
                m_tready <= ($urandom_range(99) >= 84);
            else if (phase == 3)
                m_tready <= ($urandom_range(99) >= 16);
            else
                m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        frac_res_t want;
        if (m_tvalid && m_tready)
        begin
            if (pending_q.size() == 0)
            begin
                errors++;
                $display("%0t: result with nothing pending: %h", $time, m_tdata);
            end
            else
            begin
                want = pending_q.pop_front();
                if (m_tdata[63:0] !== want.num)
                begin
                    errors++;
                    $display("%0t: numerator expected %0d actual %0d", $time,
                             $signed(want.num), $signed(m_tdata[63:0]));
                end
                if (m_tdata[126:64] !== want.den)
                begin
                    errors++;
                    $display("%0t: denominator expected %0d actual %0d", $time,
                             want.den, m_tdata[126:64]);
                end
                if (m_tuser !== want.st)
                begin
                    errors++;
                    $display("%0t: status expected %0b actual %0b", $time, want.st,
                             m_tuser);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG)
        begin
            $display("rational_arithmetic_unit_core verification failed");
            $finish;
        end
    end

    initial
    begin
        case_row_t    rows[18];
        frac_res_t    want;
        rau_pkg::op_t op;
        logic [31:0]  n1, n2;
        logic [30:0]  d1, d2;
        phase        = 0;
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;

        rows[0]  = '{rau_pkg::OP_ADD, 32'd1, 31'd2, 32'd1, 31'd3, 1'b1,
                     '{64'd5, 63'd6, 1'b0}};
        rows[1]  = '{rau_pkg::OP_ADD, 32'd0, 31'd1, 32'd0, 31'd1, 1'b1,
                     '{64'd0, 63'd1, 1'b0}};
        rows[2]  = '{rau_pkg::OP_SUB, 32'd1, 31'd2, 32'd1, 31'd2, 1'b1,
                     '{64'd0, 63'd1, 1'b0}};
        rows[3]  = '{rau_pkg::OP_MUL, 32'h8000_0000, 31'd1, 32'h8000_0000, 31'd1, 1'b1,
                     '{64'h4000_0000_0000_0000, 63'd1, 1'b0}};
        rows[4]  = '{rau_pkg::OP_DIV, 32'd5, 31'd7, 32'd0, 31'd1, 1'b1,
                     '{64'd1, 63'd0, 1'b1}};
        rows[5]  = '{rau_pkg::OP_DIV, -32'sd3, 31'd4, 32'd0, 31'd9, 1'b1,
                     '{64'hffff_ffff_ffff_ffff, 63'd0, 1'b1}};
        rows[6]  = '{rau_pkg::OP_DIV, 32'd0, 31'd1, 32'd0, 31'd1, 1'b1,
                     '{64'd0, 63'd0, 1'b1}};
        rows[7]  = '{rau_pkg::OP_DIV, 32'd1, 31'd2, -32'sd1, 31'd3, 1'b1,
                     '{-64'sd3, 63'd2, 1'b0}};
        rows[8]  = '{rau_pkg::OP_ADD, 32'd1, 31'd0, 32'd1, 31'd0, 1'b1,
                     '{64'd2, 63'd1, 1'b0}};
        rows[9]  = '{rau_pkg::OP_MUL, 32'd0, 31'd5, -32'sd7, 31'd3, 1'b1,
                     '{64'd0, 63'd1, 1'b0}};
        rows[10] = '{rau_pkg::OP_ADD, 32'h8000_0000, 31'h7fff_ffff,
                     32'h8000_0000, 31'h7fff_fffe, 1'b0, '{0, 0, 0}};
        rows[11] = '{rau_pkg::OP_SUB, 32'h8000_0000, 31'h7fff_ffff,
                     32'h7fff_ffff, 31'h7fff_fffe, 1'b0, '{0, 0, 0}};
        rows[12] = '{rau_pkg::OP_SUB, 32'h7fff_ffff, 31'd1, 32'h8000_0000, 31'd1,
                     1'b0, '{0, 0, 0}};
        rows[13] = '{rau_pkg::OP_MUL, 32'h7fff_ffff, 31'h7fff_ffff,
                     32'h8000_0000, 31'h7fff_fffe, 1'b0, '{0, 0, 0}};
        rows[14] = '{rau_pkg::OP_DIV, 32'h8000_0000, 31'h7fff_ffff,
                     32'h7fff_ffff, 31'h7fff_fffe, 1'b0, '{0, 0, 0}};
        rows[15] = '{rau_pkg::OP_DIV, 32'h7fff_ffff, 31'd1,
                     32'h8000_0000, 31'h7fff_ffff, 1'b0, '{0, 0, 0}};
        rows[16] = '{rau_pkg::OP_ADD, 32'h5555_5555, 31'h2aaa_aaaa,
                     32'haaaa_aaaa, 31'h5555_5555, 1'b0, '{0, 0, 0}};
        rows[17] = '{rau_pkg::OP_MUL, 32'hffff_ffff, 31'd0, 32'd6, 31'd4,
                     1'b0, '{0, 0, 0}};

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (rows[i])
        begin
            want = rows[i].typed ? rows[i].res
                 : reduce_fraction(rows[i].op, rows[i].n1, rows[i].d1,
                                   rows[i].n2, rows[i].d2);
            send_item(rows[i].op, rows[i].n1, rows[i].d1, rows[i].n2, rows[i].d2, want);
        end

        for (int i = 0; i < RAND_ITEMS; i++)
        begin
            phase = (i * 4) / RAND_ITEMS;
            op = rau_pkg::op_t'($urandom_range(3));
            n1 = pick_numerator();
            n2 = ($urandom_range(15) == 0) ? 32'd0 : pick_numerator();
            d1 = pick_denominator();
            d2 = pick_denominator();
            send_item(op, n1, d1, n2, d2, reduce_fraction(op, n1, d1, n2, d2));
        end
        s_tvalid <= 1'b0;

        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (600) @(posedge clk);

        if (errors == 0)
            $display("rational_arithmetic_unit_core verification clean");
        else
            $display("rational_arithmetic_unit_core verification failed");
        $finish;
    end

endmodule
